// File: hw/rtl/voxel_face_culling_assert.svh
// Assertion macros for the voxel face culling checker.
// Needs clk and rst_n in the scope of each use.
`ifndef VOXEL_FACE_CULLING_ASSERT_SVH
`define VOXEL_FACE_CULLING_ASSERT_SVH

// Check cons in the same cycle as ante.
`define VFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define VFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/vfc_pkg.sv
// Shared constants for the voxel face culling block.
// No dependencies; used by voxel_face_culling and vfc_checker.
package vfc_pkg;

    localparam int IDX_W      = 16;
    localparam int IN_ID_W    = 8;
    localparam int S_TDATA_W  = 24;
    localparam int FX_W       = 4;
    localparam int FY_W       = 8;
    localparam int FZ_W       = 4;
    localparam int DIR_W      = 3;
    localparam int FB_W       = 8;
    localparam int M_TDATA_W  = 32;
    localparam int NUM_DIRS   = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DIR_W-1:0] DIR_XN = 3'd0;
    localparam logic [DIR_W-1:0] DIR_XP = 3'd1;
    localparam logic [DIR_W-1:0] DIR_YN = 3'd2;
    localparam logic [DIR_W-1:0] DIR_YP = 3'd3;
    localparam logic [DIR_W-1:0] DIR_ZN = 3'd4;
    localparam logic [DIR_W-1:0] DIR_ZP = 3'd5;

endpackage

// File: hw/rtl/voxel_face_culling.sv
// Voxel face culling: grid store, index split and neighbour scan sequencer.
// Depends on vfc_pkg.
//
// Input stream (s_*): one transaction per item. s_tuser is the operation
// (write or query), s_tdata carries cell_index and block_id. A write stores
// the id in the grid and gives no result. A query gives one to six face
// records on the output stream (m_*), the final one with m_tlast high; an
// air cell, a cell with no exposed side or an index outside the grid gives
// a single record with m_tuser (face_valid) low and all data zero.
// Sequence: a write leaves s_tready high. A query holds s_tready low while it
// runs: the states QUO_X, REM_X, QUO_Y and REM_Y split the index into x, y
// and z on the shared multiplier, the scan then makes six neighbour reads on
// the single memory read port, then records leave at one per cycle while
// m_tready does not stall. A query outside the grid skips the split and scan
// and goes straight to its record.
// Records pass through an output register: the block keeps working while the
// last record waits, and a stalled m_tready only holds the record emission.
// Reset clears the sequencer and the output valid; grid contents are kept
// and are undefined until written.
module voxel_face_culling
    import vfc_pkg::*;
#(
    parameter int SIZE_X  = 16,
    parameter int SIZE_Y  = 256,
    parameter int SIZE_Z  = 16,
    parameter int ID_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // cell_index[15:0], block_id[23:16]
    input  logic                 s_tuser,  // operation[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // face_x[3:0], face_y[11:4], face_z[15:12],
                                           // face_direction[18:16], face_block[26:19]
    output logic                 m_tuser,  // face_valid[0]
    output logic                 m_tlast   // last_record
);

    localparam int CELL_COUNT = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int PLANE      = SIZE_X * SIZE_Y;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int XW         = $clog2(SIZE_X);
    localparam int YW         = $clog2(SIZE_Y);
    localparam int ZW         = $clog2(SIZE_Z);
    localparam int MB_W       = IDX_W + 2;
    localparam int PROD_W     = IDX_W + MB_W;
    localparam int S1         = IDX_W + XW;
    localparam int S2         = IDX_W + YW;
    localparam logic [MB_W-1:0] M1 =
        MB_W'(((64'd1 << S1) + 64'(SIZE_X) - 64'd1) / 64'(SIZE_X));
    localparam logic [MB_W-1:0] M2 =
        MB_W'(((64'd1 << S2) + 64'(SIZE_Y) - 64'd1) / 64'(SIZE_Y));

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_QUO_X = 7'b0000010,
        ST_REM_X = 7'b0000100,
        ST_QUO_Y = 7'b0001000,
        ST_REM_Y = 7'b0010000,
        ST_SCAN  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [IDX_W-1:0]      q1_reg;
    logic [XW-1:0]         x_reg;
    logic [YW-1:0]         y_reg;
    logic [ZW-1:0]         z_reg;
    logic [ID_BITS-1:0]    self_reg;
    logic [NUM_DIRS-1:0]   mask_reg;
    logic [2:0]            scan_reg;
    logic                  null_reg;
    logic [ID_BITS-1:0]    rd_data_reg;
    logic                  out_valid_reg;
    logic                  face_valid_reg;
    logic [FX_W-1:0]       face_x_reg;
    logic [FY_W-1:0]       face_y_reg;
    logic [FZ_W-1:0]       face_z_reg;
    logic [DIR_W-1:0]      face_dir_reg;
    logic [FB_W-1:0]       face_block_reg;
    logic                  last_reg;

    logic [ID_BITS-1:0]    cell_mem [CELL_COUNT];

    logic [IDX_W-1:0]      cell_index;
    logic [IN_ID_W-1:0]    block_id;
    logic                  accept;
    logic                  in_grid;
    logic                  wr_en;
    logic [AW-1:0]         base_addr;
    logic [AW-1:0]         nb_off;
    logic [AW-1:0]         nb_addr;
    logic [AW-1:0]         rd_addr;
    logic [IDX_W-1:0]      mul_a;
    logic [MB_W-1:0]       mul_b;
    logic                  mul_en;
    logic [IDX_W-1:0]      q1_comb;
    logic [IDX_W-1:0]      q2_comb;
    logic [2:0]            eval_dir;
    logic                  at_edge;
    logic                  emit_ok;
    logic                  emit;
    logic                  none;
    logic [DIR_W-1:0]      first_dir;
    logic [NUM_DIRS-1:0]   rest_mask;
    logic                  emit_last;

    assign cell_index = s_tdata[IDX_W-1:0];
    assign block_id   = s_tdata[IDX_W +: IN_ID_W];
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_grid    = int'(cell_index) < CELL_COUNT;
    assign wr_en      = accept && (s_tuser == OP_WRITE) && in_grid;
    assign base_addr  = AW'(idx_reg);
    assign q1_comb    = IDX_W'(prod_reg >> S1);
    assign q2_comb    = IDX_W'(prod_reg >> S2);
    assign eval_dir   = scan_reg - 3'd1;

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = idx_reg;
        mul_b  = M1;
        unique case (state_reg)
            ST_QUO_X:
            begin
                mul_a = idx_reg;
                mul_b = M1;
            end
            ST_REM_X:
            begin
                mul_a = q1_comb;
                mul_b = MB_W'(SIZE_X);
            end
            ST_QUO_Y:
            begin
                mul_a = q1_reg;
                mul_b = M2;
            end
            ST_REM_Y:
            begin
                mul_a = q2_comb;
                mul_b = MB_W'(SIZE_Y);
            end
            default:
                mul_en = 1'b0;
        endcase
    end

    always_comb
    begin
        case (scan_reg) inside
            DIR_XN, DIR_XP: nb_off = AW'(1);
            DIR_YN, DIR_YP: nb_off = AW'(SIZE_X);
            default:        nb_off = AW'(PLANE);
        endcase
        nb_addr = scan_reg[0] ? (base_addr + nb_off) : (base_addr - nb_off);
        rd_addr = (state_reg == ST_SCAN) ? nb_addr : base_addr;
    end

    always_comb
    begin
        unique case (eval_dir)
            DIR_XN:  at_edge = (x_reg == '0);
            DIR_XP:  at_edge = (x_reg == XW'(SIZE_X - 1));
            DIR_YN:  at_edge = (y_reg == '0);
            DIR_YP:  at_edge = (y_reg == YW'(SIZE_Y - 1));
            DIR_ZN:  at_edge = (z_reg == '0);
            DIR_ZP:  at_edge = (z_reg == ZW'(SIZE_Z - 1));
            default: at_edge = 1'b1;
        endcase
    end

    always_comb
    begin
        first_dir = DIR_XN;
        for (int i = NUM_DIRS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                first_dir = DIR_W'(i);
            end
        end
        rest_mask = mask_reg & ~(NUM_DIRS'(1) << first_dir);
        none      = null_reg || (self_reg == '0) || (mask_reg == '0);
        emit_last = none || (rest_mask == '0);
        emit_ok   = !out_valid_reg || m_tready;
        emit      = (state_reg == ST_EMIT) && emit_ok;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == OP_QUERY))
                begin
                    state_next = in_grid ? ST_QUO_X : ST_EMIT;
                end
            end
            ST_QUO_X: state_next = ST_REM_X;
            ST_REM_X: state_next = ST_QUO_Y;
            ST_QUO_Y: state_next = ST_REM_Y;
            ST_REM_Y: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_reg == 3'(NUM_DIRS))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[AW'(cell_index)] <= ID_BITS'(block_id);
        end
        rd_data_reg <= cell_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
            null_reg      <= 1'b0;
            mask_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                mask_reg      <= rest_mask;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                null_reg <= !in_grid;
                mask_reg <= '0;
                scan_reg <= '0;
            end
            if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_reg + 3'd1;
                if (scan_reg != '0)
                begin
                    mask_reg[eval_dir] <= at_edge || (rd_data_reg == '0);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= cell_index;
        end
        if (mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (state_reg == ST_REM_X)
        begin
            q1_reg   <= q1_comb;
            self_reg <= rd_data_reg;
        end
        if (state_reg == ST_QUO_Y)
        begin
            x_reg <= XW'(idx_reg - IDX_W'(prod_reg));
        end
        if (state_reg == ST_REM_Y)
        begin
            z_reg <= ZW'(q2_comb);
        end
        if ((state_reg == ST_SCAN) && (scan_reg == '0))
        begin
            y_reg <= YW'(q1_reg - IDX_W'(prod_reg));
        end
        if (emit)
        begin
            last_reg <= emit_last;
            if (none)
            begin
                face_valid_reg <= 1'b0;
                face_x_reg     <= '0;
                face_y_reg     <= '0;
                face_z_reg     <= '0;
                face_dir_reg   <= '0;
                face_block_reg <= '0;
            end
            else
            begin
                face_valid_reg <= 1'b1;
                face_x_reg     <= FX_W'(x_reg);
                face_y_reg     <= FY_W'(y_reg);
                face_z_reg     <= FZ_W'(z_reg);
                face_dir_reg   <= first_dir;
                face_block_reg <= FB_W'(self_reg);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = face_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = M_TDATA_W'({face_block_reg, face_dir_reg, face_z_reg,
                                  face_y_reg, face_x_reg});

endmodule

// File: hw/rtl/vfc_checker.sv
// Port-level checks for voxel_face_culling, attached by bind.
// Depends on vfc_pkg and voxel_face_culling_assert.svh.
`include "voxel_face_culling_assert.svh"

module vfc_checker
    import vfc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    `VFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output transaction changed")

    `VFC_ASSERT_NOW(a_empty_last, m_tvalid && !m_tuser, m_tlast, "empty record not marked last")

    `VFC_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tuser, m_tdata == '0, "empty record carries data")

    `VFC_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser == OP_QUERY), !s_tready, "input ready right after a query")

endmodule

bind voxel_face_culling vfc_checker u_vfc_checker (.*);
